// ===== rtl/rlrd_pkg.sv =====
// Shared constants for the ring longest-run direction finder.
// Holds the stream field widths and the default ring size; no dependencies.
`timescale 1ns / 1ps

package rlrd_pkg;

   // Default and supported ring size
   localparam int SENSORS_DEFAULT = 16;

   // Width of the sensor snapshot on the request stream
   localparam int IN_WIDTH = 16;

   // Response field widths
   localparam int RUN_LENGTH_W = 5;
   localparam int RUN_START_W  = 4;
   localparam int DIRECTION_W  = 5;

   // Bus widths, padded to whole bytes
   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_FIELDS_W = RUN_LENGTH_W + RUN_START_W + DIRECTION_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

endpackage

// ===== rtl/ring_longest_run_direction.sv =====
// Channel  | Group      | Payload
// ---------+------------+----------------------------------------------------
// request  | req_t*     | tdata[15:0] sensor_bits
// response | rsp_t*     | tdata run_length, run_start, direction; tuser valid
//
// One transaction per cycle while the response side does not stall. A chain
// of 2*Sensors scan cells, one per step of the doubled ring walk, then the
// response register. A stalled response holds the whole chain in place.
// Reset clears all valid flags; no clearing pass is needed.
// Top level of the ring longest-run direction finder; uses rlrd_pkg,
// rlrd_cell and rlrd_result.
`timescale 1ns / 1ps

module ring_longest_run_direction #(
   parameter int Sensors = rlrd_pkg::SENSORS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: [15:0] sensor_bits
   input  logic [rlrd_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: [4:0] run_length, [8:5] run_start, [13:9] direction, [15:14] zero
   output logic [rlrd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: [0] direction_valid
   output logic                             rsp_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready
);
   import rlrd_pkg::*;

   localparam int Steps = 2 * Sensors;
   localparam int LenW  = $clog2(Steps + 1);
   localparam int IdxW  = $clog2(Sensors);

   logic                advance;
   logic                stg_valid  [0:Steps];
   logic [IN_WIDTH-1:0] stg_bits   [0:Steps];
   logic [LenW-1:0]     stg_cur    [0:Steps];
   logic [IdxW-1:0]     stg_cstart [0:Steps];
   logic [LenW-1:0]     stg_best   [0:Steps];
   logic [IdxW-1:0]     stg_bstart [0:Steps];

   logic [RUN_LENGTH_W-1:0] run_length;
   logic [RUN_START_W-1:0]  run_start;
   logic [DIRECTION_W-1:0]  direction;

   // Advance the chain whenever the response register is free or drained
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Feed the first cell with a fresh walk state
   assign stg_valid[0]  = req_tvalid;
   assign stg_bits[0]   = req_tdata[IN_WIDTH-1:0];
   assign stg_cur[0]    = '0;
   assign stg_cstart[0] = '0;
   assign stg_best[0]   = '0;
   assign stg_bstart[0] = '0;

   // One cell per step of the doubled walk
   generate
      for (genvar k = 0; k < Steps; k++) begin : g_cell
         rlrd_cell #(
            .Idx  (k % Sensors),
            .LenW (LenW),
            .IdxW (IdxW)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (advance),
            .in_valid   (stg_valid[k]),
            .in_bits    (stg_bits[k]),
            .in_cur     (stg_cur[k]),
            .in_cstart  (stg_cstart[k]),
            .in_best    (stg_best[k]),
            .in_bstart  (stg_bstart[k]),
            .out_valid  (stg_valid[k+1]),
            .out_bits   (stg_bits[k+1]),
            .out_cur    (stg_cur[k+1]),
            .out_cstart (stg_cstart[k+1]),
            .out_best   (stg_best[k+1]),
            .out_bstart (stg_bstart[k+1])
         );
      end
   endgenerate

   // Finish the walk and register the response
   rlrd_result #(
      .Sensors (Sensors),
      .LenW    (LenW),
      .IdxW    (IdxW)
   ) u_result (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (stg_valid[Steps]),
      .in_best       (stg_best[Steps]),
      .in_bstart     (stg_bstart[Steps]),
      .out_valid     (rsp_tvalid),
      .out_length    (run_length),
      .out_start     (run_start),
      .out_direction (direction),
      .out_dir_valid (rsp_tuser)
   );

   assign rsp_tdata = RSP_TDATA_W'({direction, run_start, run_length});

endmodule

// ===== rtl/rlrd_cell.sv =====
// One scan step of the doubled ring walk: updates the current and best run.
// Depends on rlrd_pkg for the snapshot width.
`timescale 1ns / 1ps

module rlrd_cell #(
   parameter int Idx  = 0,
   parameter int LenW = 6,
   parameter int IdxW = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic                             in_valid,
   input  logic [rlrd_pkg::IN_WIDTH-1:0]    in_bits,
   input  logic [LenW-1:0]                  in_cur,
   input  logic [IdxW-1:0]                  in_cstart,
   input  logic [LenW-1:0]                  in_best,
   input  logic [IdxW-1:0]                  in_bstart,
   output logic                             out_valid,
   output logic [rlrd_pkg::IN_WIDTH-1:0]    out_bits,
   output logic [LenW-1:0]                  out_cur,
   output logic [IdxW-1:0]                  out_cstart,
   output logic [LenW-1:0]                  out_best,
   output logic [IdxW-1:0]                  out_bstart
);
   import rlrd_pkg::*;

   logic                active;
   logic                valid_ff;
   logic [IN_WIDTH-1:0] bits_ff;
   logic [LenW-1:0]     cur_ff, cur_in;
   logic [IdxW-1:0]     cstart_ff, cstart_in;
   logic [LenW-1:0]     best_ff, best_in;
   logic [IdxW-1:0]     bstart_ff, bstart_in;

   // Sensors past the snapshot width read as inactive
   generate
      if (Idx < IN_WIDTH) begin : g_tap
         assign active = in_bits[Idx];
      end else begin : g_off
         assign active = 1'b0;
      end
   endgenerate

   // Extend or break the current run, promote it when strictly longer
   always_comb begin
      cur_in    = '0;
      cstart_in = in_cstart;
      best_in   = in_best;
      bstart_in = in_bstart;
      if (active) begin
         cur_in = in_cur + LenW'(1);
         if (in_cur == '0) begin
            cstart_in = IdxW'(Idx);
         end
         if (cur_in > in_best) begin
            best_in   = cur_in;
            bstart_in = cstart_in;
         end
      end
   end

   // Control: valid flag moves with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Payload: hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         bits_ff   <= in_bits;
         cur_ff    <= cur_in;
         cstart_ff <= cstart_in;
         best_ff   <= best_in;
         bstart_ff <= bstart_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_bits   = bits_ff;
   assign out_cur    = cur_ff;
   assign out_cstart = cstart_ff;
   assign out_best   = best_ff;
   assign out_bstart = bstart_ff;

endmodule

// ===== rtl/rlrd_result.sv =====
// Final stage: caps the doubled-scan length, forms the midpoint direction
// and holds the response register. Depends on rlrd_pkg for field widths.
`timescale 1ns / 1ps

module rlrd_result #(
   parameter int Sensors = rlrd_pkg::SENSORS_DEFAULT,
   parameter int LenW    = 6,
   parameter int IdxW    = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic                              in_valid,
   input  logic [LenW-1:0]                   in_best,
   input  logic [IdxW-1:0]                   in_bstart,
   output logic                              out_valid,
   output logic [rlrd_pkg::RUN_LENGTH_W-1:0] out_length,
   output logic [rlrd_pkg::RUN_START_W-1:0]  out_start,
   output logic [rlrd_pkg::DIRECTION_W-1:0]  out_direction,
   output logic                              out_dir_valid
);
   import rlrd_pkg::*;

   localparam int DirW = $clog2(3 * Sensors);

   logic [LenW-1:0]         len_cap;
   logic [DirW-1:0]         mid_sum;
   logic [DirW-1:0]         mid_wrap;
   logic                    dir_ok;
   logic                    valid_ff;
   logic [RUN_LENGTH_W-1:0] length_ff;
   logic [RUN_START_W-1:0]  start_ff;
   logic [DIRECTION_W-1:0]  direction_ff;
   logic                    dir_valid_ff;

   // Cap a full ring at the ring size; midpoint in half-spacing steps
   always_comb begin
      len_cap  = (in_best > LenW'(Sensors)) ? LenW'(Sensors) : in_best;
      dir_ok   = (len_cap != '0) && (len_cap != LenW'(Sensors));
      mid_sum  = (DirW'(in_bstart) << 1) + DirW'(len_cap) - DirW'(1);
      mid_wrap = (mid_sum >= DirW'(2 * Sensors)) ? mid_sum - DirW'(2 * Sensors) : mid_sum;
      if (!dir_ok) begin
         mid_wrap = '0;
      end
   end

   // Control: response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Payload: response fields, held while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         length_ff    <= RUN_LENGTH_W'(len_cap);
         start_ff     <= RUN_START_W'(in_bstart);
         direction_ff <= DIRECTION_W'(mid_wrap);
         dir_valid_ff <= dir_ok;
      end
   end

   assign out_valid     = valid_ff;
   assign out_length    = length_ff;
   assign out_start     = start_ff;
   assign out_direction = direction_ff;
   assign out_dir_valid = dir_valid_ff;

endmodule

// ===== rtl/rlrd_checker.sv =====
// Port-level checks for the ring longest-run direction finder, bound to the
// top level. Depends on rlrd_pkg for field widths.
`timescale 1ns / 1ps

module rlrd_checker #(
   parameter int Sensors = rlrd_pkg::SENSORS_DEFAULT
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic [rlrd_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);
   import rlrd_pkg::*;

   logic [RUN_LENGTH_W-1:0] chk_length;
   logic [RUN_START_W-1:0]  chk_start;
   logic [DIRECTION_W-1:0]  chk_dir;
   logic [6:0]              exp_sum;
   logic [6:0]              exp_dir;

   assign chk_length = rsp_tdata[RUN_LENGTH_W-1:0];
   assign chk_start  = rsp_tdata[RUN_LENGTH_W +: RUN_START_W];
   assign chk_dir    = rsp_tdata[RUN_LENGTH_W + RUN_START_W +: DIRECTION_W];

   // Expected midpoint for rings whose indexes fit the response fields
   always_comb begin
      exp_sum = {2'b00, chk_start, 1'b0} + {2'b00, chk_length} - 7'd1;
      exp_dir = (exp_sum >= 7'(2 * Sensors)) ? exp_sum - 7'(2 * Sensors) : exp_sum;
   end

   // Hold the response while the consumer stalls
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // A stalled response stalls the request side
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while response stalled");

   // Empty ring reports zero start and no direction
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && chk_length == '0 |-> chk_start == '0 && chk_dir == '0 && !rsp_tuser)
      else $error("empty ring result malformed");

   // Invalid direction reads as zero
   a_dir_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> chk_dir == '0)
      else $error("invalid direction not zero");

   // Valid direction is the run midpoint
   a_dir_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && (Sensors <= 16) |->
         chk_dir == exp_dir[DIRECTION_W-1:0] && chk_length != '0)
      else $error("direction is not the run midpoint");

endmodule

bind ring_longest_run_direction rlrd_checker #(.Sensors(Sensors)) u_rlrd_checker (.*);

// ===== verif/ring_longest_run_direction_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for ring_longest_run_direction: streams sensor snapshots,
// predicts the longest circular run, its start and direction, and checks each response.
// Depends on rlrd_pkg and the ring_longest_run_direction RTL.

module ring_longest_run_direction_tb;
   import rlrd_pkg::*;

   localparam int RING             = SENSORS_DEFAULT;
   localparam int LATENCY          = 2 * RING + 1;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int HOLD_OFF_CYCLES  = 160;
   localparam int FILL_ITEMS       = 150;
   localparam int CHUNK            = 50;
   localparam int CHUNKS_PER_PHASE = 8;
   localparam int START_LO         = RUN_LENGTH_W;
   localparam int DIR_LO           = RUN_LENGTH_W + RUN_START_W;
   localparam int NUM_DIRECTED     = 22;

   typedef struct packed {
      logic [RUN_LENGTH_W-1:0] run_length;
      logic [RUN_START_W-1:0]  run_start;
      logic [DIRECTION_W-1:0]  direction;
      logic                    dir_valid;
   } ring_run_type;

   // One directed snapshot; want is used only when typed is set
   typedef struct packed {
      logic [IN_WIDTH-1:0] sensor_bits;
      logic                typed;
      ring_run_type        want;
   } snapshot_row_type;

   // Fields of want: run_length, run_start, direction, dir_valid
   snapshot_row_type directed_rows [NUM_DIRECTED] = '{
      {16'h0000, 1'b1, 5'd0,  4'd0,  5'd0,  1'b0},   // empty ring
      {16'hFFFF, 1'b1, 5'd16, 4'd0,  5'd0,  1'b0},   // full ring
      {16'h0001, 1'b1, 5'd1,  4'd0,  5'd0,  1'b1},   // lone first sensor
      {16'h8000, 1'b1, 5'd1,  4'd15, 5'd30, 1'b1},   // lone last sensor
      {16'h7FFF, 1'b1, 5'd15, 4'd0,  5'd14, 1'b1},   // all but last
      {16'hFFFE, 1'b1, 5'd15, 4'd1,  5'd16, 1'b1},   // all but first
      {16'h8001, 1'b1, 5'd2,  4'd15, 5'd31, 1'b1},   // run wrapping through sensor 0
      {16'h0303, 1'b1, 5'd2,  4'd0,  5'd1,  1'b1},   // tie, first run wins
      {16'h5555, 1'b0, 15'd0},
      {16'hAAAA, 1'b0, 15'd0},
      {16'hEFFF, 1'b0, 15'd0},
      {16'hC003, 1'b0, 15'd0},
      {16'h00F0, 1'b0, 15'd0},
      {16'hF00F, 1'b0, 15'd0},
      {16'h0F0F, 1'b0, 15'd0},
      {16'h1248, 1'b0, 15'd0},
      {16'h7FFE, 1'b0, 15'd0},
      {16'h8421, 1'b0, 15'd0},
      {16'hFF00, 1'b0, 15'd0},
      {16'h00FF, 1'b0, 15'd0},
      {16'h8180, 1'b0, 15'd0},
      {16'h3C3C, 1'b0, 15'd0}
   };

   logic                   clock;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;

   ring_run_type expected_runs [$];
   int        mismatch_count   = 0;
   int        rsp_count        = 0;
   int        send_idle_pct    = 0;
   int        recv_stall_pct   = 0;
   int        hold_off_request = 0;
   int        hold_left        = 0;
   int        quiet_cycles     = 0;

   ring_longest_run_direction #(
      .Sensors(RING)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready)
   );

   // Clock and a single reset pulse
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Scan the ring twice; a run replaces the best only when strictly longer
   function automatic ring_run_type find_longest_run(input logic [IN_WIDTH-1:0] bits);
      ring_run_type r;
      int        best_len;
      int        best_start;
      int        cur_len;
      int        cur_start;
      int        idx;
      int        dir;
      logic      lit;
      best_len   = 0;
      best_start = 0;
      cur_len    = 0;
      cur_start  = 0;
      dir        = 0;
      for (int k = 0; k < 2 * RING; k++) begin
         idx = k % RING;
         lit = (idx < IN_WIDTH) ? bits[idx] : 1'b0;
         if (lit) begin
            if (cur_len == 0) cur_start = idx;
            cur_len++;
            if (cur_len > best_len) begin
               best_len   = cur_len;
               best_start = cur_start;
            end
         end else begin
            cur_len = 0;
         end
      end
      if (best_len > RING) best_len = RING;
      r.run_length = best_len[RUN_LENGTH_W-1:0];
      r.run_start  = best_start[RUN_START_W-1:0];
      r.dir_valid  = 1'b0;
      // Midpoint of the run in half-spacing steps
      if (best_len > 0 && best_len < RING) begin
         dir         = (2 * best_start + best_len - 1) % (2 * RING);
         r.dir_valid = 1'b1;
      end
      r.direction = dir[DIRECTION_W-1:0];
      return r;
   endfunction

   function automatic logic [IN_WIDTH-1:0] arc_mask(input int first, input int len);
      logic [IN_WIDTH-1:0] m;
      m = '0;
      for (int j = 0; j < len; j++) m[(first + j) % RING] = 1'b1;
      return m;
   endfunction

   // Mix of plain random words and shaped ring patterns
   function automatic logic [IN_WIDTH-1:0] random_snapshot();
      logic [31:0]         raw;
      logic [IN_WIDTH-1:0] snap;
      int                  first;
      int                  len;
      raw   = $urandom;
      first = $urandom_range(RING - 1);
      len   = $urandom_range(1, RING);
      case ($urandom_range(9))
         0, 1, 2: snap = raw[IN_WIDTH-1:0];
         3:       snap = arc_mask(first, len);
         4, 5:    snap = arc_mask(first, $urandom_range(1, 6))
                       | arc_mask($urandom_range(RING - 1), $urandom_range(1, 6))
                       | (raw[0] ? arc_mask($urandom_range(RING - 1), 2) : '0);
         6:       snap = ~(arc_mask(first, 1) | arc_mask($urandom_range(RING - 1), 1));
         7:       snap = arc_mask(first, 1) | arc_mask($urandom_range(RING - 1), 1);
         8: begin
            // two runs of equal length to exercise the tie rule
            len  = $urandom_range(1, 7);
            snap = arc_mask(first, len)
                 | arc_mask(first + len + 1 + $urandom_range(RING - 2 * len - 2), len);
         end
         default: begin
            case (raw[1:0])
               2'd0:    snap = '0;
               2'd1:    snap = '1;
               default: snap = raw[IN_WIDTH+1:2];
            endcase
         end
      endcase
      return snap;
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatch_count++;
      $display("response %0d: %s got %0h expected %0h", rsp_count, what, got, want);
   endtask

   // Offer one snapshot after a random gap; record the expected response on accept
   task automatic offer_snapshot(input logic [IN_WIDTH-1:0] bits, input logic typed,
                                 input ring_run_type want);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_runs.push_back(typed ? want : find_longest_run(bits));
   endtask

   task automatic drain_expected();
      while (expected_runs.size() != 0) @(posedge clock);
   endtask

   // Receiver: random stalls, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_off_request > 0) begin
         hold_left        = hold_off_request;
         hold_off_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each response transaction with the oldest expectation
   always @(posedge clock) begin : check_responses
      ring_run_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (expected_runs.size() == 0) begin
            report_mismatch("unexpected response", 16'(rsp_tdata), 16'd0);
         end else begin
            want = expected_runs.pop_front();
            if (rsp_tdata[0 +: RUN_LENGTH_W] !== want.run_length)
               report_mismatch("run_length", 16'(rsp_tdata[0 +: RUN_LENGTH_W]),
                               16'(want.run_length));
            if (rsp_tdata[START_LO +: RUN_START_W] !== want.run_start)
               report_mismatch("run_start", 16'(rsp_tdata[START_LO +: RUN_START_W]),
                               16'(want.run_start));
            if (rsp_tdata[DIR_LO +: DIRECTION_W] !== want.direction)
               report_mismatch("direction", 16'(rsp_tdata[DIR_LO +: DIRECTION_W]),
                               16'(want.direction));
            if (rsp_tuser !== want.dir_valid)
               report_mismatch("direction_valid", 16'(rsp_tuser), 16'(want.dir_valid));
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Stimulus: directed rows, then random phases with varied idling
   initial begin
      int phase;
      while (reset) @(posedge clock);

      foreach (directed_rows[r])
         offer_snapshot(directed_rows[r].sensor_bits, directed_rows[r].typed,
                        directed_rows[r].want);
      req_tvalid <= 1'b0;
      drain_expected();

      for (phase = 0; phase < 4; phase++) begin
         for (int c = 0; c < CHUNKS_PER_PHASE; c++) begin
            // some chunks run without any idling
            if ($urandom_range(3) == 0) begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end else begin
               send_idle_pct  = (phase == 1) ? 82 : (phase == 3) ? 11 : 0;
               recv_stall_pct = (phase == 2) ? 82 : (phase == 3) ? 11 : 0;
            end
            for (int i = 0; i < CHUNK; i++) offer_snapshot(random_snapshot(), 1'b0, '0);
         end
         if (phase == 0) begin
            // hold the receiver off while offering, so the pipeline fills and stalls
            send_idle_pct    = 0;
            recv_stall_pct   = 0;
            hold_off_request = HOLD_OFF_CYCLES;
            for (int i = 0; i < FILL_ITEMS; i++) offer_snapshot(random_snapshot(), 1'b0, '0);
         end
         if (phase == 1) begin
            // pause the sender until every response is back
            req_tvalid <= 1'b0;
            drain_expected();
         end
      end

      req_tvalid <= 1'b0;
      drain_expected();
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
